/* rtl/affine_2d_transform_unit_core_macros.svh */
// Assertion macros for the affine transform unit.
// Used by the top level; expects clk and rst_n in scope.
`ifndef AFFINE_2D_TRANSFORM_UNIT_CORE_MACROS_SVH
`define AFFINE_2D_TRANSFORM_UNIT_CORE_MACROS_SVH

// same-cycle implication
`define AFF2D_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AFF2D_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/aff2d_pkg.sv */
// Shared types, constants and helper functions of the affine transform unit.
// No dependencies.
package aff2d_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 32;
    localparam int OPND_W        = 33;
    localparam int PROD_W        = 66;
    localparam int ADJ_W         = 64;
    localparam int ACC_W         = 128;

    typedef logic [2:0] opcode_t;
    localparam opcode_t OP_IDENTITY  = 3'd0;
    localparam opcode_t OP_LOAD_ROW  = 3'd1;
    localparam opcode_t OP_TRANSLATE = 3'd2;
    localparam opcode_t OP_SCALE     = 3'd3;
    localparam opcode_t OP_ROTATE    = 3'd4;
    localparam opcode_t OP_INVERT    = 3'd5;
    localparam opcode_t OP_POINT     = 3'd6;
    localparam opcode_t OP_READ_ROW  = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE, ST_FETCH, ST_MUL, ST_ACC, ST_STORE, ST_DIV_GO, ST_DIV_WAIT, ST_FINISH
    } state_t;

    typedef enum logic [1:0] {MODE_PROD, MODE_COF, MODE_DET, MODE_DIV} mode_t;

    typedef struct packed {
        logic              start;
        logic [ADJ_W-1:0]  num_mag;
        logic [ACC_W-1:0]  den_mag;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [ACC_W-1:0]  quo_mag;
    } div_rsp_t;

    typedef struct packed {
        logic              flag;
        logic [WORD_W-1:0] value;
    } sat_t;

    // clamp a wide two's complement value to 32 bits
    function automatic sat_t sat32(input logic [ACC_W-1:0] v);
        sat_t r;
        r.flag  = 1'b0;
        r.value = v[WORD_W-1:0];
        if (v[ACC_W-1]) begin
            if (!(&v[ACC_W-1:WORD_W-1])) begin
                r.flag  = 1'b1;
                r.value = {1'b1, {(WORD_W-1){1'b0}}};
            end
        end
        else if (|v[ACC_W-1:WORD_W-1]) begin
            r.flag  = 1'b1;
            r.value = {1'b0, {(WORD_W-1){1'b1}}};
        end
        return r;
    endfunction

    // cofactor operands {p, q, r, s} as {row, col} pairs, adj = m[p]*m[q] - m[r]*m[s]
    function automatic logic [15:0] cof_pos(input logic [1:0] row, input logic [1:0] col);
        logic [15:0] r;
        unique case ({row, col})
            4'b0000: r = 16'b0101_1010_0110_1001;
            4'b0001: r = 16'b0010_1001_0001_1010;
            4'b0010: r = 16'b0001_0110_0010_0101;
            4'b0100: r = 16'b0110_1000_0100_1010;
            4'b0101: r = 16'b0000_1010_0010_1000;
            4'b0110: r = 16'b0010_0100_0000_0110;
            4'b1000: r = 16'b0100_1001_0101_1000;
            4'b1001: r = 16'b0001_1000_0000_1001;
            4'b1010: r = 16'b0000_0101_0001_0100;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/aff2d_div.sv */
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
// Depends on aff2d_pkg.
module aff2d_div
    import aff2d_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    // numerator is |adj| << 2F, so 64 + 2F bits
    localparam int STEPS = ADJ_W + 2 * FRAC_BITS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [ACC_W-1:0] rem_reg, quo_reg, den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [ACC_W-1:0] rem_shift, rem_diff;
    logic             fits;

    assign rem_shift = {rem_reg[ACC_W-2:0], quo_reg[ACC_W-1]};
    assign fits      = rem_shift >= den_reg;
    assign rem_diff  = rem_shift - den_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(STEPS);
            end
            else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= {req.num_mag, {(ACC_W-ADJ_W){1'b0}}};
            den_reg <= req.den_mag;
        end
        else if (busy_reg) begin
            rem_reg <= fits ? rem_diff : rem_shift;
            quo_reg <= {quo_reg[ACC_W-2:0], fits};
        end
    end

    assign rsp.busy    = busy_reg;
    assign rsp.done    = done_reg;
    assign rsp.quo_mag = quo_reg;

endmodule

/* rtl/affine_2d_transform_unit_core.sv */
// Top level of the 2-D homogeneous affine transform unit.
// Depends on aff2d_pkg, aff2d_div and affine_2d_transform_unit_core_macros.svh.
//
// Holds a 3x3 matrix in signed Q(31-F).F (F = FRAC_BITS), reset to identity, and runs one
// command per input transfer, giving exactly one result transfer per command. All products
// go through one shared 33x33 multiplier with a registered product and a 128-bit
// accumulator; each product steps through fetch, multiply and accumulate under a small
// sequencer, and the block is not ready while a command runs. Translate, scale and rotate
// post-multiply with nine entries of three products each; invert forms the nine cofactors
// and the determinant, then, unless the determinant is zero, runs nine divisions in the
// bit-serial divider. A finished result sits in the output register and the next command
// may start meanwhile.
`include "affine_2d_transform_unit_core_macros.svh"

module affine_2d_transform_unit_core
    import aff2d_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [2:0]               opcode,
    input  logic [1:0]               row_select,
    input  logic signed [WORD_W-1:0] value_a,
    input  logic signed [WORD_W-1:0] value_b,
    input  logic signed [WORD_W-1:0] value_c,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [WORD_W-1:0] out_a,
    output logic signed [WORD_W-1:0] out_b,
    output logic signed [WORD_W-1:0] out_c,
    output logic                     singular,
    output logic                     saturated
);

    localparam logic [WORD_W-1:0] ONE_WORD = WORD_W'(longint'(1) << FRAC_BITS);
    localparam logic signed [OPND_W-1:0] ONE_OPND = OPND_W'(longint'(1) << FRAC_BITS);

    // post-multiply operand B[k][c]; for a point transform the column is the vector (x, y, 1)
    function automatic logic signed [OPND_W-1:0] bval(
        input opcode_t op, input logic [1:0] k, input logic [1:0] c,
        input logic signed [OPND_W-1:0] a, input logic signed [OPND_W-1:0] b);
        logic signed [OPND_W-1:0] v;
        v = '0;
        unique case (op)
            OP_TRANSLATE: begin
                if (k == c) v = ONE_OPND;
                else if (k == 2'd0 && c == 2'd2) v = a;
                else if (k == 2'd1 && c == 2'd2) v = b;
            end
            OP_SCALE: begin
                if (k == 2'd0 && c == 2'd0) v = a;
                else if (k == 2'd1 && c == 2'd1) v = b;
                else if (k == 2'd2 && c == 2'd2) v = ONE_OPND;
            end
            OP_ROTATE: begin
                if (k == c && k != 2'd2) v = a;
                else if (k == 2'd0 && c == 2'd1) v = -b;
                else if (k == 2'd1 && c == 2'd0) v = b;
                else if (k == 2'd2 && c == 2'd2) v = ONE_OPND;
            end
            OP_POINT: begin
                if (k == 2'd0) v = a;
                else if (k == 2'd1) v = b;
                else v = ONE_OPND;
            end
            default: v = '0;
        endcase
        return v;
    endfunction

    // ---- state ----
    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;

    logic [2:0][WORD_W-1:0] m_reg   [3];
    logic [2:0][WORD_W-1:0] t_reg   [3];
    logic [2:0][ADJ_W-1:0]  adj_reg [3];

    opcode_t                  op_reg;
    logic signed [WORD_W-1:0] va_reg, vb_reg;
    logic [1:0]               r_reg, c_reg;
    logic [2:0]               term_reg;
    logic signed [OPND_W-1:0] x_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [ACC_W-1:0]         acc_reg, det_reg;
    logic                     neg_reg;
    logic [WORD_W-1:0]        res_a_reg, res_b_reg, res_c_reg;
    logic                     sing_reg, sat_reg;
    logic                     out_valid_reg;
    logic [WORD_W-1:0]        out_a_reg, out_b_reg, out_c_reg;
    logic                     out_sing_reg, out_sat_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // ---- sequencer status ----
    logic in_fire, out_free, last_term, last_ent, acc_zero;
    logic [1:0] r_adv, c_adv;

    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign acc_zero = (acc_reg == '0);

    always_comb begin
        unique case (mode_reg)
            MODE_PROD: last_term = (term_reg == 3'd2);
            MODE_COF:  last_term = (term_reg == 3'd1);
            MODE_DET:  last_term = (term_reg == 3'd5);
            MODE_DIV:  last_term = 1'b1;
        endcase
    end

    always_comb begin
        if (mode_reg == MODE_PROD && op_reg == OP_POINT) begin
            last_ent = (r_reg == 2'd1);
            r_adv    = r_reg + 2'd1;
            c_adv    = 2'd0;
        end
        else begin
            last_ent = (r_reg == 2'd2) && (c_reg == 2'd2);
            r_adv    = (c_reg == 2'd2) ? r_reg + 2'd1 : r_reg;
            c_adv    = (c_reg == 2'd2) ? 2'd0 : c_reg + 2'd1;
        end
    end

    // ---- next state ----
    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    priority case (opcode)
                        OP_IDENTITY, OP_LOAD_ROW, OP_READ_ROW: state_next = ST_FINISH;
                        OP_INVERT: begin
                            state_next = ST_FETCH;
                            mode_next  = MODE_COF;
                        end
                        default: begin
                            state_next = ST_FETCH;
                            mode_next  = MODE_PROD;
                        end
                    endcase
                end
            end
            ST_FETCH: state_next = ST_MUL;
            ST_MUL:   state_next = ST_ACC;
            ST_ACC:   state_next = last_term ? ST_STORE : ST_FETCH;
            ST_STORE: begin
                unique case (mode_reg)
                    MODE_PROD: state_next = last_ent ? ST_FINISH : ST_FETCH;
                    MODE_COF: begin
                        state_next = ST_FETCH;
                        if (last_ent) mode_next = MODE_DET;
                    end
                    MODE_DET: begin
                        if (acc_zero) state_next = ST_FINISH;
                        else begin
                            state_next = ST_DIV_GO;
                            mode_next  = MODE_DIV;
                        end
                    end
                    MODE_DIV: state_next = ST_FINISH;
                endcase
            end
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_rsp.done) state_next = last_ent ? ST_FINISH : ST_DIV_GO;
            end
            ST_FINISH: if (out_free) state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_PROD;
        end
        else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

    // ---- outputs of the sequencer ----
    assign in_ready = (state_reg == ST_IDLE);

    logic [1:0]  rd_row, rd_col, ad_row, ad_col;
    logic [15:0] cof;

    assign cof = cof_pos(r_reg, c_reg);

    always_comb begin
        rd_row = 2'd0;
        rd_col = 2'd0;
        unique case (state_reg)
            ST_IDLE: rd_row = row_select;
            ST_FETCH: begin
                unique case (mode_reg)
                    MODE_PROD: {rd_row, rd_col} = {r_reg, term_reg[1:0]};
                    MODE_COF:  {rd_row, rd_col} = term_reg[0] ? cof[7:4] : cof[15:12];
                    MODE_DET:  {rd_row, rd_col} = {term_reg[2:1], 2'd0};
                    MODE_DIV:  {rd_row, rd_col} = 4'd0;
                endcase
            end
            ST_MUL: {rd_row, rd_col} = term_reg[0] ? cof[3:0] : cof[11:8];
            default: {rd_row, rd_col} = 4'd0;
        endcase
        if (mode_reg == MODE_DET) {ad_row, ad_col} = {2'd0, term_reg[2:1]};
        else {ad_row, ad_col} = {r_reg, c_reg};
    end

    // single matrix read port and single adjugate read port
    logic [2:0][WORD_W-1:0] rd_vec;
    logic [WORD_W-1:0]      rd_word;
    logic [2:0][ADJ_W-1:0]  ad_vec;
    logic [ADJ_W-1:0]       ad_word;

    always_comb begin
        unique case (rd_row)
            2'd0:    rd_vec = m_reg[0];
            2'd1:    rd_vec = m_reg[1];
            2'd2:    rd_vec = m_reg[2];
            default: rd_vec = '0;
        endcase
        unique case (rd_col)
            2'd0:    rd_word = rd_vec[0];
            2'd1:    rd_word = rd_vec[1];
            2'd2:    rd_word = rd_vec[2];
            default: rd_word = '0;
        endcase
        unique case (ad_row)
            2'd0:    ad_vec = adj_reg[0];
            2'd1:    ad_vec = adj_reg[1];
            2'd2:    ad_vec = adj_reg[2];
            default: ad_vec = '0;
        endcase
        unique case (ad_col)
            2'd0:    ad_word = ad_vec[0];
            2'd1:    ad_word = ad_vec[1];
            2'd2:    ad_word = ad_vec[2];
            default: ad_word = '0;
        endcase
    end

    // ---- shared multiplier and accumulator ----
    logic signed [OPND_W-1:0] y_sel;
    logic signed [PROD_W-1:0] prod_next;
    logic [ACC_W-1:0]         addend, acc_next;

    always_comb begin
        unique case (mode_reg)
            MODE_PROD: y_sel = bval(op_reg, term_reg[1:0], c_reg,
                                    OPND_W'(va_reg), OPND_W'(vb_reg));
            MODE_COF:  y_sel = OPND_W'($signed(rd_word));
            // determinant: high half signed, weight 2^32; low half unsigned
            MODE_DET:  y_sel = term_reg[0] ? {1'b0, ad_word[WORD_W-1:0]}
                                           : {ad_word[ADJ_W-1], ad_word[ADJ_W-1:WORD_W]};
            MODE_DIV:  y_sel = '0;
        endcase
    end

    assign prod_next = x_reg * y_sel;

    always_comb begin
        addend = ACC_W'(prod_reg);
        if (mode_reg == MODE_DET && !term_reg[0]) addend = addend << WORD_W;
        if (mode_reg == MODE_COF && term_reg[0]) acc_next = acc_reg - addend;
        else acc_next = acc_reg + addend;
    end

    // ---- result shaping ----
    sat_t             prod_sat, div_sat;
    logic [ACC_W-1:0] acc_shift, quo_signed;

    assign acc_shift  = ACC_W'($signed(acc_reg) >>> FRAC_BITS);
    assign prod_sat   = sat32(acc_shift);
    assign quo_signed = neg_reg ? -div_rsp.quo_mag : div_rsp.quo_mag;
    assign div_sat    = sat32(quo_signed);

    // ---- divider ----
    assign div_req.start   = (state_reg == ST_DIV_GO);
    assign div_req.num_mag = ad_word[ADJ_W-1] ? -ad_word : ad_word;
    assign div_req.den_mag = det_reg[ACC_W-1] ? -det_reg : det_reg;

    aff2d_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ---- sequencer counters and flags ----
    logic store_prod, store_cof, store_det, div_take, copy_t, load_ident;

    assign store_prod = (state_reg == ST_STORE) && (mode_reg == MODE_PROD);
    assign store_cof  = (state_reg == ST_STORE) && (mode_reg == MODE_COF);
    assign store_det  = (state_reg == ST_STORE) && (mode_reg == MODE_DET);
    assign div_take   = (state_reg == ST_DIV_WAIT) && div_rsp.done;
    // the scratch matrix is complete by the finish cycle, last entry included
    assign copy_t     = (state_reg == ST_FINISH) && out_free
                        && (op_reg == OP_TRANSLATE || op_reg == OP_SCALE
                            || op_reg == OP_ROTATE || (op_reg == OP_INVERT && !sing_reg));
    assign load_ident = (in_fire && opcode == OP_IDENTITY) || (store_det && acc_zero);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            r_reg         <= 2'd0;
            c_reg         <= 2'd0;
            term_reg      <= 3'd0;
            sing_reg      <= 1'b0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (in_fire) begin
                r_reg    <= 2'd0;
                c_reg    <= 2'd0;
                term_reg <= 3'd0;
                sing_reg <= 1'b0;
                sat_reg  <= 1'b0;
            end
            if (state_reg == ST_ACC) term_reg <= last_term ? 3'd0 : term_reg + 3'd1;
            if (store_prod || store_cof || div_take) begin
                r_reg <= last_ent ? 2'd0 : r_adv;
                c_reg <= last_ent ? 2'd0 : c_adv;
            end
            if (store_prod) sat_reg <= sat_reg | prod_sat.flag;
            if (div_take)   sat_reg <= sat_reg | div_sat.flag;
            if (store_det && acc_zero) sing_reg <= 1'b1;
            if (state_reg == ST_FINISH && out_free) out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
        end
    end

    // current matrix: reset and written as whole rows or all at once
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    m_reg[i][j] <= (i == j) ? ONE_WORD : '0;
        end
        else if (load_ident) begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    m_reg[i][j] <= (i == j) ? ONE_WORD : '0;
        end
        else if (in_fire && opcode == OP_LOAD_ROW && row_select != 2'd3) begin
            m_reg[row_select] <= {value_c, value_b, value_a};
        end
        else if (copy_t) begin
            for (int i = 0; i < 3; i++) m_reg[i] <= t_reg[i];
        end
    end

    // payload registers
    always_ff @(posedge clk) begin
        if (in_fire) begin
            op_reg    <= opcode;
            va_reg    <= value_a;
            vb_reg    <= value_b;
            acc_reg   <= '0;
            if (opcode == OP_READ_ROW) {res_c_reg, res_b_reg, res_a_reg} <= rd_vec;
            else begin
                res_a_reg <= '0;
                res_b_reg <= '0;
                res_c_reg <= '0;
            end
        end
        if (state_reg == ST_FETCH) x_reg <= OPND_W'($signed(rd_word));
        if (state_reg == ST_MUL)   prod_reg <= prod_next;
        if (state_reg == ST_ACC)   acc_reg <= acc_next;
        if (state_reg == ST_STORE) acc_reg <= '0;
        if (store_prod) begin
            if (op_reg == OP_POINT) begin
                if (r_reg == 2'd0) res_a_reg <= prod_sat.value;
                else res_b_reg <= prod_sat.value;
            end
            else t_reg[r_reg][c_reg] <= prod_sat.value;
        end
        if (store_cof) adj_reg[r_reg][c_reg] <= acc_reg[ADJ_W-1:0];
        if (store_det) det_reg <= acc_reg;
        if (state_reg == ST_DIV_GO) neg_reg <= ad_word[ADJ_W-1] ^ det_reg[ACC_W-1];
        if (div_take) t_reg[r_reg][c_reg] <= div_sat.value;
        if (state_reg == ST_FINISH && out_free) begin
            out_a_reg    <= res_a_reg;
            out_b_reg    <= res_b_reg;
            out_c_reg    <= res_c_reg;
            out_sing_reg <= sing_reg;
            out_sat_reg  <= sat_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_a     = out_a_reg;
    assign out_b     = out_b_reg;
    assign out_c     = out_c_reg;
    assign singular  = out_sing_reg;
    assign saturated = out_sat_reg;

    // ---- assertions ----
    `AFF2D_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
    `AFF2D_ASSERT_IMPL(a_singular_clean, out_valid && singular, !saturated && out_a == '0 && out_b == '0 && out_c == '0, "singular result not clean")
    `AFF2D_ASSERT_IMPL(a_div_start_idle, div_req.start, !div_rsp.busy, "divider restarted while busy")
    `AFF2D_ASSERT_IMPL(a_readback_clean, out_valid && out_c != '0, !singular && !saturated, "column 2 set on non-read")

endmodule
